// ===== design/gphtrk_pkg.sv =====
package gphtrk_pkg;

  localparam int SAMPLE_W = 16;
  localparam int LINGER_W = 10;
  localparam int SMOOTH_W = 9;
  localparam int ROOT_W   = 16;
  localparam int RAD_W    = 2 * ROOT_W;
  localparam int MUL_W    = SAMPLE_W + 2;
  localparam int PROD_W   = 2 * MUL_W;
  localparam int ADDR_W   = 4;
  localparam int DATA_W   = 32;

  localparam logic [SMOOTH_W-1:0] SMOOTH_MAX = SMOOTH_W'(256);
  localparam logic [SMOOTH_W-1:0] SMOOTH_RST = SMOOTH_W'(64);
  localparam logic [LINGER_W-1:0] LINGER_RST = LINGER_W'(60);
  localparam logic [SAMPLE_W-1:0] PEAK_THRESH = SAMPLE_W'(13);

  typedef enum logic [1:0] {
    REG_SMOOTH = 2'd0,
    REG_LINGER = 2'd1,
    REG_SHOW   = 2'd2
  } reg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_LAT,
    ST_ADD_LAT,
    ST_MUL_LON,
    ST_ADD_LON,
    ST_SQ_A,
    ST_SQ_B,
    ST_SQ_SUM,
    ST_ROOT_GO,
    ST_ROOT,
    ST_PEAK,
    ST_DONE
  } state_e;

endpackage

// ===== design/gforce_peak_hold_tracker.sv =====
// Peak-hold G tracker. One request carries a frame of lateral and longitudinal
// acceleration (signed Q7.8) plus valid, crashed and clear flags; each request
// yields exactly one result with the EMA-smoothed felt G, its magnitude, and the
// held peak marker with its visibility. From acceptance to result an item runs
// the EMA on the shared 18x18 multiplier (lateral multiply and add, then
// longitudinal multiply and add), then two magnitude passes (raw sample, then
// smoothed vector) with a peak update between them, and then loads the output
// register. Each pass squares both axes, adds the squares and runs the 16-step
// bit-serial square root with its start and done handshake; a new request is
// taken only once the previous one is through. in_stall_o stays high from acceptance
// until the result is moved into the output register; a waiting result does not
// block the next request. Registers at 0x0 (smooth_factor), 0x4 (linger_frames)
// and 0x8 (show_marker) must be written by the user through the APB port only
// while the block is idle; the block itself does not enforce this.
module gforce_peak_hold_tracker (
  input  logic                            clk_i,
  input  logic                            rst_ni,

  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic signed [gphtrk_pkg::SAMPLE_W-1:0] accel_lateral_i,
  input  logic signed [gphtrk_pkg::SAMPLE_W-1:0] accel_longitudinal_i,
  input  logic                            sample_valid_i,
  input  logic                            crashed_i,
  input  logic                            clear_tracking_i,

  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic signed [gphtrk_pkg::SAMPLE_W-1:0] smooth_lateral_o,
  output logic signed [gphtrk_pkg::SAMPLE_W-1:0] smooth_longitudinal_o,
  output logic [gphtrk_pkg::SAMPLE_W-1:0] live_magnitude_o,
  output logic signed [gphtrk_pkg::SAMPLE_W-1:0] peak_lateral_o,
  output logic signed [gphtrk_pkg::SAMPLE_W-1:0] peak_longitudinal_o,
  output logic [gphtrk_pkg::SAMPLE_W-1:0] peak_magnitude_o,
  output logic                            peak_visible_o,
  output logic                            live_valid_o,

  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [gphtrk_pkg::ADDR_W-1:0]   paddr,
  input  logic [gphtrk_pkg::DATA_W-1:0]   pwdata,
  output logic [gphtrk_pkg::DATA_W-1:0]   prdata,
  output logic                            pready
);
  import gphtrk_pkg::*;

  localparam logic signed [SAMPLE_W-1:0] SMAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic signed [SAMPLE_W-1:0] SMIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

  function automatic logic signed [SAMPLE_W-1:0] neg_sat(input logic signed [SAMPLE_W-1:0] v);
    if (v == SMIN) begin
      return SMAX;
    end
    return -v;
  endfunction

  // configuration
  logic [SMOOTH_W-1:0] smooth_q;
  logic [LINGER_W-1:0] linger_cfg_q;
  logic                show_q;
  logic                cfg_wr;
  reg_idx_e            cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smooth_q     <= SMOOTH_RST;
      linger_cfg_q <= LINGER_RST;
      show_q       <= 1'b1;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_SMOOTH: smooth_q     <= pwdata[SMOOTH_W-1:0];
        REG_LINGER: linger_cfg_q <= pwdata[LINGER_W-1:0];
        REG_SHOW:   show_q       <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_SMOOTH: prdata = DATA_W'(smooth_q);
      REG_LINGER: prdata = DATA_W'(linger_cfg_q);
      REG_SHOW:   prdata = DATA_W'(show_q);
      default:    prdata = '0;
    endcase
  end

  // sequencer and datapath state
  state_e state_q, state_d;

  logic signed [SAMPLE_W-1:0] lat_q, lon_q;
  logic                       valid_q, crashed_q, just_q, was_crashed_q, pass_q;
  logic signed [SAMPLE_W-1:0] s_lat_q, s_lon_q;
  logic signed [SAMPLE_W-1:0] m_lat_q, m_lon_q;
  logic [SAMPLE_W-1:0]        m_mag_q, cur_q, live_mag_q;
  logic [LINGER_W-1:0]        linger_q;
  logic signed [PROD_W-1:0]   prod_q;
  logic [RAD_W-1:0]           acc_q;

  logic                       out_valid_q;
  logic signed [SAMPLE_W-1:0] o_s_lat_q, o_s_lon_q, o_m_lat_q, o_m_lon_q;
  logic [SAMPLE_W-1:0]        o_live_mag_q, o_m_mag_q;
  logic                       o_vis_q, o_live_q;

  logic                       accept;
  logic                       load_out;
  logic                       root_start;
  logic                       root_done;
  logic [ROOT_W-1:0]          root;

  logic signed [MUL_W-1:0]    mul_a, mul_b;
  logic signed [PROD_W-1:0]   mul_p;
  logic [SMOOTH_W-1:0]        k_eff;
  logic signed [SAMPLE_W-1:0] sq_a, sq_b, ema_s;
  logic signed [PROD_W-1:0]   ema_sum;
  logic signed [SAMPLE_W-1:0] ema_res;

  logic was_eff, do_clear;

  assign accept     = in_valid_i & ~in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);
  assign k_eff      = (smooth_q > SMOOTH_MAX) ? SMOOTH_MAX : smooth_q;
  assign mul_p      = mul_a * mul_b;

  assign sq_a = pass_q ? s_lat_q : lat_q;
  assign sq_b = pass_q ? s_lon_q : lon_q;

  assign ema_s   = (state_q == ST_ADD_LAT) ? s_lat_q : s_lon_q;
  assign ema_sum = PROD_W'(ema_s) + (prod_q >>> 8);
  always_comb begin
    if (ema_sum > PROD_W'(SMAX)) begin
      ema_res = SMAX;
    end else if (ema_sum < PROD_W'(SMIN)) begin
      ema_res = SMIN;
    end else begin
      ema_res = ema_sum[SAMPLE_W-1:0];
    end
  end

  assign was_eff  = clear_tracking_i ? 1'b0 : was_crashed_q;
  assign do_clear = clear_tracking_i | (was_eff & ~crashed_i);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:    if (accept) state_d = ST_MUL_LAT;
      ST_MUL_LAT: state_d = ST_ADD_LAT;
      ST_ADD_LAT: state_d = ST_MUL_LON;
      ST_MUL_LON: state_d = ST_ADD_LON;
      ST_ADD_LON: state_d = ST_SQ_A;
      ST_SQ_A:    state_d = ST_SQ_B;
      ST_SQ_B:    state_d = ST_SQ_SUM;
      ST_SQ_SUM:  state_d = ST_ROOT_GO;
      ST_ROOT_GO: state_d = ST_ROOT;
      ST_ROOT:    if (root_done) state_d = pass_q ? ST_DONE : ST_PEAK;
      ST_PEAK:    state_d = ST_SQ_A;
      ST_DONE:    if (!out_valid_q || !out_stall_i) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    mul_a      = '0;
    mul_b      = '0;
    root_start = 1'b0;
    load_out   = 1'b0;
    case (state_q)
      ST_MUL_LAT: begin
        mul_a = MUL_W'(lat_q) - MUL_W'(s_lat_q);
        mul_b = MUL_W'({1'b0, k_eff});
      end
      ST_MUL_LON: begin
        mul_a = MUL_W'(lon_q) - MUL_W'(s_lon_q);
        mul_b = MUL_W'({1'b0, k_eff});
      end
      ST_SQ_A: begin
        mul_a = MUL_W'(sq_a);
        mul_b = MUL_W'(sq_a);
      end
      ST_SQ_B: begin
        mul_a = MUL_W'(sq_b);
        mul_b = MUL_W'(sq_b);
      end
      ST_ROOT_GO: root_start = 1'b1;
      ST_DONE:    load_out   = !out_valid_q || !out_stall_i;
      default: ;
    endcase
  end

  gphtrk_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (root_start),
    .rad_i   (acc_q),
    .done_o  (root_done),
    .root_o  (root)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      was_crashed_q <= 1'b0;
      s_lat_q       <= '0;
      s_lon_q       <= '0;
      m_lat_q       <= '0;
      m_lon_q       <= '0;
      m_mag_q       <= '0;
      linger_q      <= '0;
      out_valid_q   <= 1'b0;
      pass_q        <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= load_out | (out_valid_q & out_stall_i);
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            was_crashed_q <= crashed_i;
            pass_q        <= 1'b0;
            if (do_clear) begin
              s_lat_q  <= '0;
              s_lon_q  <= '0;
              m_lat_q  <= '0;
              m_lon_q  <= '0;
              m_mag_q  <= '0;
              linger_q <= '0;
            end
          end
        end
        ST_ADD_LAT: s_lat_q <= valid_q ? ema_res : '0;
        ST_ADD_LON: s_lon_q <= valid_q ? ema_res : '0;
        ST_ROOT:    if (root_done && !pass_q) pass_q <= 1'b1;
        ST_PEAK: begin
          if (valid_q && !crashed_q) begin
            if ((SAMPLE_W+1)'(cur_q) > (SAMPLE_W+1)'(m_mag_q) + (SAMPLE_W+1)'(PEAK_THRESH)) begin
              m_mag_q  <= cur_q;
              m_lat_q  <= lat_q;
              m_lon_q  <= lon_q;
              linger_q <= '0;
            end else if ((SAMPLE_W+1)'(cur_q) + (SAMPLE_W+1)'(PEAK_THRESH)
                         < (SAMPLE_W+1)'(m_mag_q)
                         && linger_q == '0 && m_mag_q > PEAK_THRESH) begin
              linger_q <= linger_cfg_q;
            end else if (linger_q != '0) begin
              linger_q <= linger_q - LINGER_W'(1);
              if (linger_q == LINGER_W'(1)) m_mag_q <= '0;
            end
          end else if (crashed_q) begin
            // seed on crash onset; otherwise hold the marker frozen
            if (just_q && valid_q && linger_q == '0 && cur_q > PEAK_THRESH) begin
              m_lat_q  <= lat_q;
              m_lon_q  <= lon_q;
              m_mag_q  <= cur_q;
              linger_q <= linger_cfg_q;
            end
          end else begin
            linger_q <= '0;
            m_mag_q  <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      lat_q     <= neg_sat(accel_lateral_i);
      lon_q     <= neg_sat(accel_longitudinal_i);
      valid_q   <= sample_valid_i;
      crashed_q <= crashed_i;
      just_q    <= crashed_i & ~was_eff;
    end
    case (state_q)
      ST_MUL_LAT, ST_MUL_LON, ST_SQ_A: prod_q <= mul_p;
      ST_SQ_B: begin
        acc_q  <= prod_q[RAD_W-1:0];
        prod_q <= mul_p;
      end
      ST_SQ_SUM: acc_q <= acc_q + prod_q[RAD_W-1:0];
      ST_ROOT: begin
        if (root_done) begin
          if (pass_q) live_mag_q <= SAMPLE_W'(root);
          else        cur_q      <= SAMPLE_W'(root);
        end
      end
      default: ;
    endcase
    if (load_out) begin
      o_s_lat_q    <= s_lat_q;
      o_s_lon_q    <= s_lon_q;
      o_live_mag_q <= live_mag_q;
      o_m_lat_q    <= m_lat_q;
      o_m_lon_q    <= m_lon_q;
      o_m_mag_q    <= m_mag_q;
      o_vis_q      <= (show_q | crashed_q) && linger_q != '0 && m_mag_q > PEAK_THRESH;
      o_live_q     <= valid_q;
    end
  end

  assign out_valid_o           = out_valid_q;
  assign smooth_lateral_o      = o_s_lat_q;
  assign smooth_longitudinal_o = o_s_lon_q;
  assign live_magnitude_o      = o_live_mag_q;
  assign peak_lateral_o        = o_m_lat_q;
  assign peak_longitudinal_o   = o_m_lon_q;
  assign peak_magnitude_o      = o_m_mag_q;
  assign peak_visible_o        = o_vis_q;
  assign live_valid_o          = o_live_q;

endmodule

// ===== design/gphtrk_isqrt.sv =====
module gphtrk_isqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [gphtrk_pkg::RAD_W-1:0]  rad_i,
  output logic                          done_o,
  output logic [gphtrk_pkg::ROOT_W-1:0] root_o
);
  import gphtrk_pkg::*;

  localparam int CNT_W = $clog2(ROOT_W);
  localparam int REM_W = ROOT_W + 4;

  logic [RAD_W-1:0]  rad_q;
  logic [REM_W-1:0]  rem_q;
  logic [ROOT_W-1:0] root_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              busy_q;
  logic              done_q;

  logic [REM_W-1:0]  rem_sh;
  logic [REM_W-1:0]  trial;
  logic              fits;

  // restoring root: two radicand bits in, one root bit out per cycle
  assign rem_sh = {rem_q[REM_W-3:0], rad_q[RAD_W-1 -: 2]};
  assign trial  = REM_W'({root_q, 2'b01});
  assign fits   = rem_sh >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(ROOT_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q <= {rad_q[RAD_W-3:0], 2'b00};
      if (fits) begin
        rem_q  <= rem_sh - trial;
        root_q <= {root_q[ROOT_W-2:0], 1'b1};
      end else begin
        rem_q  <= rem_sh;
        root_q <= {root_q[ROOT_W-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

// ===== design/gphtrk_checker.sv =====
module gphtrk_checker (
  input logic                                  clk_i,
  input logic                                  rst_ni,
  input logic                                  in_valid_i,
  input logic                                  in_stall_o,
  input logic                                  out_valid_o,
  input logic                                  out_stall_i,
  input logic signed [gphtrk_pkg::SAMPLE_W-1:0] smooth_lateral_o,
  input logic signed [gphtrk_pkg::SAMPLE_W-1:0] smooth_longitudinal_o,
  input logic [gphtrk_pkg::SAMPLE_W-1:0]        live_magnitude_o,
  input logic [gphtrk_pkg::SAMPLE_W-1:0]        peak_magnitude_o,
  input logic                                  peak_visible_o,
  input logic                                  live_valid_o
);
  import gphtrk_pkg::*;

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(smooth_lateral_o)
      && $stable(live_magnitude_o) && $stable(peak_magnitude_o))
    else $error("result changed while stalled");

  // the sequencer is busy right after taking a request
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request taken without going busy");

  // invalid frame snaps the smoothed vector to zero
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !live_valid_o |-> smooth_lateral_o == '0
      && smooth_longitudinal_o == '0 && live_magnitude_o == '0)
    else $error("smoothed output nonzero on invalid frame");

  a_visible_thresh: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && peak_visible_o |-> peak_magnitude_o > PEAK_THRESH)
    else $error("marker visible below threshold");

endmodule

bind gforce_peak_hold_tracker gphtrk_checker u_gphtrk_checker (
  .clk_i                 (clk_i),
  .rst_ni                (rst_ni),
  .in_valid_i            (in_valid_i),
  .in_stall_o            (in_stall_o),
  .out_valid_o           (out_valid_o),
  .out_stall_i           (out_stall_i),
  .smooth_lateral_o      (smooth_lateral_o),
  .smooth_longitudinal_o (smooth_longitudinal_o),
  .live_magnitude_o      (live_magnitude_o),
  .peak_magnitude_o      (peak_magnitude_o),
  .peak_visible_o        (peak_visible_o),
  .live_valid_o          (live_valid_o)
);

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import gphtrk_pkg::*;

  localparam int     SAMPLE_SPAN  = 1 << SAMPLE_W;
  localparam longint G_MAX        = (longint'(1) << (SAMPLE_W - 1)) - 1;
  localparam longint G_MIN        = -G_MAX - 1;
  localparam longint HYST         = longint'(PEAK_THRESH);
  localparam int     SETTLE_TAIL  = 64;
  localparam int     HOLD_CYCLES  = 400;
  localparam int     IDLE_LIMIT   = 3000;
  localparam int     PHASES       = 5;
  localparam int     PHASE_ITEMS  = 150;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] lat;
    logic signed [SAMPLE_W-1:0] lon;
    logic                       sample_ok;
    logic                       crashed;
    logic                       clr;
  } frame_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sm_lat;
    logic signed [SAMPLE_W-1:0] sm_lon;
    logic [SAMPLE_W-1:0]        live_mag;
    logic signed [SAMPLE_W-1:0] pk_lat;
    logic signed [SAMPLE_W-1:0] pk_lon;
    logic [SAMPLE_W-1:0]        pk_mag;
    logic                       pk_vis;
    logic                       live_vld;
  } gforce_t;

  typedef struct packed {
    frame_t  req;
    logic    typed;
    gforce_t want;
  } dir_row_t;

  localparam gforce_t NO_READOUT = '0;

  // typed rows: after reset, plain zero frame, clear with an invalid sample
  localparam dir_row_t DIR_TABLE [22] = '{
    '{'{16'sd0, 16'sd0, 1'b0, 1'b0, 1'b0}, 1'b1,
      '{16'sd0, 16'sd0, 16'd0, 16'sd0, 16'sd0, 16'd0, 1'b0, 1'b0}},
    '{'{16'sd0, 16'sd0, 1'b1, 1'b0, 1'b0}, 1'b1,
      '{16'sd0, 16'sd0, 16'd0, 16'sd0, 16'sd0, 16'd0, 1'b0, 1'b1}},
    '{'{16'sh8000, 16'sh8000, 1'b1, 1'b0, 1'b0}, 1'b0, NO_READOUT},
    '{'{16'sh7fff, 16'sh7fff, 1'b1, 1'b0, 1'b0}, 1'b0, NO_READOUT},
    '{'{16'sh8000, 16'sh7fff, 1'b1, 1'b0, 1'b0}, 1'b0, NO_READOUT},
    '{'{16'sd0, 16'sd0, 1'b1, 1'b0, 1'b0}, 1'b0, NO_READOUT},
    '{'{16'sd0, 16'sd0, 1'b0, 1'b0, 1'b0}, 1'b0, NO_READOUT},
    '{'{-16'sd14, 16'sd0, 1'b1, 1'b0, 1'b0}, 1'b0, NO_READOUT},
    '{'{-16'sd13, 16'sd0, 1'b1, 1'b0, 1'b0}, 1'b0, NO_READOUT},
    '{'{16'sd0, 16'sd0, 1'b1, 1'b0, 1'b0}, 1'b0, NO_READOUT},
    '{'{16'sd0, -16'sd26, 1'b1, 1'b0, 1'b0}, 1'b0, NO_READOUT},
    '{'{16'sd0, 16'sd0, 1'b0, 1'b0, 1'b0}, 1'b0, NO_READOUT},
    '{'{-16'sd5000, 16'sd3000, 1'b1, 1'b1, 1'b0}, 1'b0, NO_READOUT},
    '{'{16'sd100, 16'sd100, 1'b1, 1'b1, 1'b0}, 1'b0, NO_READOUT},
    '{'{16'sd0, 16'sd0, 1'b0, 1'b1, 1'b0}, 1'b0, NO_READOUT},
    '{'{-16'sd200, -16'sd200, 1'b1, 1'b0, 1'b0}, 1'b0, NO_READOUT},
    '{'{16'sd0, 16'sd0, 1'b1, 1'b1, 1'b0}, 1'b0, NO_READOUT},
    '{'{16'sd4000, 16'sd0, 1'b1, 1'b1, 1'b1}, 1'b0, NO_READOUT},
    '{'{16'sd4000, 16'sd0, 1'b1, 1'b0, 1'b1}, 1'b0, NO_READOUT},
    '{'{16'sh8000, 16'sd0, 1'b0, 1'b1, 1'b0}, 1'b0, NO_READOUT},
    '{'{16'sd0, 16'sd0, 1'b0, 1'b0, 1'b1}, 1'b1,
      '{16'sd0, 16'sd0, 16'd0, 16'sd0, 16'sd0, 16'd0, 1'b0, 1'b0}},
    '{'{16'sh7fff, 16'sh8000, 1'b1, 1'b0, 1'b0}, 1'b0, NO_READOUT}
  };

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                       in_valid  = 1'b0;
  logic                       in_stall;
  logic signed [SAMPLE_W-1:0] accel_lat = '0;
  logic signed [SAMPLE_W-1:0] accel_lon = '0;
  logic                       smp_valid = 1'b0;
  logic                       crash_in  = 1'b0;
  logic                       clr_in    = 1'b0;

  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic signed [SAMPLE_W-1:0] smooth_lat_o, smooth_lon_o, peak_lat_o, peak_lon_o;
  logic [SAMPLE_W-1:0]        live_mag_o, peak_mag_o;
  logic                       peak_vis_o, live_vld_o;

  logic                       psel    = 1'b0;
  logic                       penable = 1'b0;
  logic                       pwrite  = 1'b0;
  logic [ADDR_W-1:0]          paddr   = '0;
  logic [DATA_W-1:0]          pwdata  = '0;
  logic [DATA_W-1:0]          prdata;
  logic                       pready;

  // shadow of the block's registers and tracking state
  logic [SMOOTH_W-1:0] cfg_smooth = SMOOTH_RST;
  logic [LINGER_W-1:0] cfg_linger = LINGER_RST;
  logic                cfg_show   = 1'b1;

  longint sm_lat, sm_lon, mk_lat, mk_lon, mk_mag;
  int     linger_cnt;
  bit     crash_mem;

  gforce_t readout_q[$];
  int      mismatches = 0;
  int      rx_count   = 0;
  int      tx_burst   = 0;
  int      rx_burst   = 0;
  int      ep_left    = 0;
  int      ep_kind, ep_amp;

  always #4 clk = ~clk;

  gforce_peak_hold_tracker dut (
    .clk_i                 (clk),
    .rst_ni                (rst_n),
    .in_valid_i            (in_valid),
    .in_stall_o            (in_stall),
    .accel_lateral_i       (accel_lat),
    .accel_longitudinal_i  (accel_lon),
    .sample_valid_i        (smp_valid),
    .crashed_i             (crash_in),
    .clear_tracking_i      (clr_in),
    .out_valid_o           (out_valid),
    .out_stall_i           (out_stall),
    .smooth_lateral_o      (smooth_lat_o),
    .smooth_longitudinal_o (smooth_lon_o),
    .live_magnitude_o      (live_mag_o),
    .peak_lateral_o        (peak_lat_o),
    .peak_longitudinal_o   (peak_lon_o),
    .peak_magnitude_o      (peak_mag_o),
    .peak_visible_o        (peak_vis_o),
    .live_valid_o          (live_vld_o),
    .psel                  (psel),
    .penable               (penable),
    .pwrite                (pwrite),
    .paddr                 (paddr),
    .pwdata                (pwdata),
    .prdata                (prdata),
    .pready                (pready)
  );

  function automatic longint felt_g(logic signed [SAMPLE_W-1:0] raw);
    longint v;
    v = -longint'(raw);
    return (v > G_MAX) ? G_MAX : v;
  endfunction

  // floor((x - s) * k / 256) via arithmetic shift, then clamp to the sample range
  function automatic longint ema_step(longint s, longint x, longint k);
    longint r;
    r = s + (((x - s) * k) >>> 8);
    if (r > G_MAX) r = G_MAX;
    if (r < G_MIN) r = G_MIN;
    return r;
  endfunction

  function automatic longint vec_mag(longint a, longint b);
    longint unsigned rem, root, probe;
    rem = longint'(a * a + b * b);
    root = 0;
    probe = 64'd1 << 62;
    while (probe > rem) probe >>= 2;
    while (probe != 0) begin
      if (rem >= root + probe) begin
        rem -= root + probe;
        root = (root >> 1) + probe;
      end else begin
        root >>= 1;
      end
      probe >>= 2;
    end
    return longint'(root);
  endfunction

  function automatic void clear_tracking();
    sm_lat = 0;
    sm_lon = 0;
    mk_lat = 0;
    mk_lon = 0;
    mk_mag = 0;
    linger_cnt = 0;
  endfunction

  function automatic gforce_t track_frame(frame_t f);
    longint  lat, lon, k, cur;
    bit      fresh_crash, live;
    gforce_t r;
    lat = felt_g(f.lat);
    lon = felt_g(f.lon);
    k = (cfg_smooth > SMOOTH_MAX) ? longint'(SMOOTH_MAX) : longint'(cfg_smooth);
    if (f.clr) begin
      clear_tracking();
      crash_mem = 1'b0;
    end
    if (crash_mem && !f.crashed) clear_tracking();
    fresh_crash = f.crashed && !crash_mem;
    crash_mem = f.crashed;
    live = f.sample_ok && !f.crashed;

    if (f.sample_ok) begin
      sm_lat = ema_step(sm_lat, lat, k);
      sm_lon = ema_step(sm_lon, lon, k);
    end else begin
      sm_lat = 0;
      sm_lon = 0;
    end

    if (live) begin
      cur = vec_mag(lat, lon);
      if (cur > mk_mag + HYST) begin
        mk_mag = cur;
        mk_lat = lat;
        mk_lon = lon;
        linger_cnt = 0;
      end else if (cur < mk_mag - HYST && linger_cnt == 0 && mk_mag > HYST) begin
        linger_cnt = int'(cfg_linger);
      end else if (linger_cnt > 0) begin
        linger_cnt--;
        if (linger_cnt == 0) mk_mag = 0;
      end
    end else if (f.crashed) begin
      // seed the marker from the raw sample on the first crashed frame
      if (fresh_crash && f.sample_ok && linger_cnt == 0) begin
        cur = vec_mag(lat, lon);
        if (cur > HYST) begin
          mk_lat = lat;
          mk_lon = lon;
          mk_mag = cur;
          linger_cnt = int'(cfg_linger);
        end
      end
    end else begin
      linger_cnt = 0;
      mk_mag = 0;
    end

    r.sm_lat   = SAMPLE_W'(sm_lat);
    r.sm_lon   = SAMPLE_W'(sm_lon);
    r.live_mag = SAMPLE_W'(vec_mag(sm_lat, sm_lon));
    r.pk_lat   = SAMPLE_W'(mk_lat);
    r.pk_lon   = SAMPLE_W'(mk_lon);
    r.pk_mag   = SAMPLE_W'(mk_mag);
    r.pk_vis   = (cfg_show || f.crashed) && linger_cnt > 0 && mk_mag > HYST;
    r.live_vld = f.sample_ok;
    return r;
  endfunction

  function automatic int draw_wait(inout int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) begin
      burst = $urandom_range(8, 30);
      return 0;
    end
    return $urandom_range(0, 6);
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] sample_within(int amp);
    if (amp >= SAMPLE_SPAN / 2) return SAMPLE_W'($urandom());
    return SAMPLE_W'(int'($urandom_range(0, 2 * amp)) - amp);
  endfunction

  // Mostly episodes of driving, crashes and dropouts; a tenth is raw noise.
  function automatic frame_t next_random_frame();
    frame_t f;
    if (ep_left == 0) begin
      ep_left = $urandom_range(3, 24);
      ep_kind = $urandom_range(0, 9);
      case ($urandom_range(0, 3))
        0:       ep_amp = 40;
        1:       ep_amp = 400;
        2:       ep_amp = 6000;
        default: ep_amp = SAMPLE_SPAN / 2;
      endcase
    end
    ep_left--;
    f.lat = sample_within(ep_amp);
    f.lon = sample_within(ep_amp);
    f.clr = ($urandom_range(0, 49) == 0);
    if (ep_kind <= 5) begin
      f.sample_ok = 1'b1;
      f.crashed = 1'b0;
      // quiet frames let the signal drop under the held peak
      if ($urandom_range(0, 3) == 0) begin
        f.lat = sample_within(10);
        f.lon = sample_within(10);
      end
    end else if (ep_kind <= 7) begin
      f.sample_ok = ($urandom_range(0, 7) != 0);
      f.crashed = 1'b1;
    end else if (ep_kind == 8) begin
      f.sample_ok = 1'b0;
      f.crashed = 1'b0;
    end else begin
      f = frame_t'($urandom_range(0, 7)) | (frame_t'($urandom()) << 3);
      f.clr = ($urandom_range(0, 9) == 0);
    end
    return f;
  endfunction

  task automatic send_frame(frame_t f, logic typed, gforce_t want);
    int      gap;
    gforce_t pred;
    gap = draw_wait(tx_burst);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    accel_lat <= f.lat;
    accel_lon <= f.lon;
    smp_valid <= f.sample_ok;
    crash_in  <= f.crashed;
    clr_in    <= f.clr;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    pred = track_frame(f);
    readout_q.insert(readout_q.size(), typed ? want : pred);
  endtask

  task automatic cfg_write(reg_idx_e idx, logic [DATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_SMOOTH: cfg_smooth = val[SMOOTH_W-1:0];
      REG_LINGER: cfg_linger = val[LINGER_W-1:0];
      REG_SHOW:   cfg_show   = val[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic settle_block();
    in_valid <= 1'b0;
    while (readout_q.size() != 0) @(posedge clk);
    repeat (SETTLE_TAIL) @(posedge clk);
  endtask

  initial begin : stimulus
    frame_t              f;
    logic [SMOOTH_W-1:0] k_set;
    logic [LINGER_W-1:0] linger_set;
    logic                show_set;
    clear_tracking();
    crash_mem = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < $size(DIR_TABLE); i++)
      send_frame(DIR_TABLE[i].req, DIR_TABLE[i].typed, DIR_TABLE[i].want);

    for (int ph = 0; ph < PHASES; ph++) begin
      settle_block();
      case (ph)
        0: begin
          k_set = SMOOTH_MAX;
          linger_set = LINGER_W'(2);
          show_set = 1'b1;
        end
        1: begin
          k_set = '0;
          linger_set = '1;
          show_set = 1'b0;
        end
        2: begin
          k_set = '1;
          linger_set = '0;
          show_set = 1'b1;
        end
        3: begin
          k_set = SMOOTH_W'($urandom_range(1, 255));
          linger_set = LINGER_W'($urandom_range(1, 12));
          show_set = 1'($urandom_range(0, 1));
        end
        default: begin
          k_set = SMOOTH_W'($urandom_range(0, (1 << SMOOTH_W) - 1));
          linger_set = LINGER_W'($urandom_range(0, 40));
          show_set = 1'b1;
        end
      endcase
      cfg_write(REG_SMOOTH, DATA_W'(k_set));
      cfg_write(REG_LINGER, DATA_W'(linger_set));
      cfg_write(REG_SHOW, DATA_W'(show_set));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        f = next_random_frame();
        send_frame(f, 1'b0, NO_READOUT);
      end
    end

    settle_block();
    if (mismatches == 0 && readout_q.size() == 0) begin
      $display("gforce_peak_hold_tracker: match");
    end else begin
      $display("gforce_peak_hold_tracker: mismatch");
    end
    $finish;
  end

  initial begin : result_side
    int      n;
    gforce_t got, want;
    wait (rst_n);
    forever begin
      // long hold-offs let the block fill up and stall new requests
      if (rx_count == 60 || rx_count == 400) n = HOLD_CYCLES;
      else n = draw_wait(rx_burst);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      forever begin
        @(posedge clk);
        if (out_valid) break;
      end
      got.sm_lat   = smooth_lat_o;
      got.sm_lon   = smooth_lon_o;
      got.live_mag = live_mag_o;
      got.pk_lat   = peak_lat_o;
      got.pk_lon   = peak_lon_o;
      got.pk_mag   = peak_mag_o;
      got.pk_vis   = peak_vis_o;
      got.live_vld = live_vld_o;
      if (readout_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result %0d arrived with nothing outstanding", rx_count);
      end else begin
        want = readout_q.pop_front();
        if (got.sm_lat !== want.sm_lat || got.sm_lon !== want.sm_lon ||
            got.live_mag !== want.live_mag || got.pk_lat !== want.pk_lat ||
            got.pk_lon !== want.pk_lon || got.pk_mag !== want.pk_mag ||
            got.pk_vis !== want.pk_vis || got.live_vld !== want.live_vld) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result %0d exp sm=%0d,%0d live=%0d pk=%0d,%0d,%0d vis=%0b vld=%0b",
                     rx_count, want.sm_lat, want.sm_lon, want.live_mag, want.pk_lat,
                     want.pk_lon, want.pk_mag, want.pk_vis, want.live_vld);
            $display("result %0d got sm=%0d,%0d live=%0d pk=%0d,%0d,%0d vis=%0b vld=%0b",
                     rx_count, got.sm_lat, got.sm_lon, got.live_mag, got.pk_lat,
                     got.pk_lon, got.pk_mag, got.pk_vis, got.live_vld);
          end
        end
      end
      rx_count++;
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
        idle = 0;
      else
        idle++;
    end
    $display("gforce_peak_hold_tracker: mismatch");
    $finish;
  end

endmodule
